[hw/rtl/ldd_pkg.sv]
// ----------------------------------------------------------------------------
// ldd_pkg
// Shared types and constants of the lock graph deadlock detector.
// ----------------------------------------------------------------------------
package ldd_pkg;

   localparam int NODE_SLOTS_DEF = 64;
   localparam int KEY_BITS_DEF   = 32;
   localparam int ID_BITS        = 32;
   localparam int NODES_OUT_BITS = 7;

   // event kinds
   typedef enum logic [1:0] {
      FN_REQUEST  = 2'd0,
      FN_ACQUIRED = 2'd1,
      FN_RELEASED = 2'd2,
      FN_UNUSED   = 2'd3
   } ldd_func_type;

   // result codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DEADLOCK = 2'd1,
      ST_FULL     = 2'd2,
      ST_SPARE    = 2'd3
   } ldd_status_type;

   // controller to datapath commands
   typedef struct packed {
      logic           load;
      logic           scan_cmp;
      logic           alloc_t;
      logic           alloc_m;
      logic           edge_rd;
      logic           edge_wr;
      logic           row_sel_m;
      logic           wr_set;
      logic           dfs_clear;
      logic           root;
      logic           push;
      logic           pop;
      logic           pop_load;
      logic           rsp_load;
      ldd_status_type rsp_status;
   } ldd_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_done;
      logic full;
      logic root_none;
      logic cycle;
      logic cand_any;
      logic sp_zero;
   } ldd_stat_type;

endpackage

[hw/rtl/ldd_req_if.sv]
// ----------------------------------------------------------------------------
// ldd_req_if
// Event channel: valid/ready handshake with one event word.
// ----------------------------------------------------------------------------
interface ldd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [31:0] thread_id;
   logic [31:0] mutex_id;

   modport source (output valid, func, thread_id, mutex_id, input ready);
   modport sink (input valid, func, thread_id, mutex_id, output ready);
endinterface

[hw/rtl/ldd_rsp_if.sv]
// ----------------------------------------------------------------------------
// ldd_rsp_if
// Result channel: valid/ready handshake with one result word.
// ----------------------------------------------------------------------------
interface ldd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [6:0] nodes_in_use;

   modport source (output valid, status, nodes_in_use, input ready);
   modport sink (input valid, status, nodes_in_use, output ready);
endinterface

[hw/rtl/ldd_ctrl.sv]
// ----------------------------------------------------------------------------
// ldd_ctrl
// Sequencer: node lookup, allocation, edge updates and the cycle search.
// ----------------------------------------------------------------------------
module ldd_ctrl
   import ldd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic [1:0]   req_func,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  ldd_stat_type st,
   output ldd_cmd_type  cmd
);

   typedef enum logic [10:0] {
      S_IDLE    = 11'b000_0000_0001,
      S_SCAN_RD = 11'b000_0000_0010,
      S_SCAN_CM = 11'b000_0000_0100,
      S_ALLOC_T = 11'b000_0000_1000,
      S_ALLOC_M = 11'b000_0001_0000,
      S_EDGE_RD = 11'b000_0010_0000,
      S_EDGE_WR = 11'b000_0100_0000,
      S_ROOT    = 11'b000_1000_0000,
      S_ROW     = 11'b001_0000_0000,
      S_POP     = 11'b010_0000_0000,
      S_DONE    = 11'b100_0000_0000
   } ldd_state_type;

   ldd_state_type  state_ff, state_in;
   ldd_func_type   func_ff, func_in;
   ldd_status_type status_ff, status_in;
   logic           sel_m_ff, sel_m_in;
   logic           set_ff, set_in;
   logic           phase_ff, phase_in;
   logic           undo_ff, undo_in;
   logic           rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      status_in    = status_ff;
      sel_m_in     = sel_m_ff;
      set_in       = set_ff;
      phase_in     = phase_ff;
      undo_in      = undo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd           = '0;
      cmd.row_sel_m = sel_m_ff;
      cmd.wr_set    = set_ff;
      cmd.rsp_status = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load  = 1'b1;
               func_in   = ldd_func_type'(req_func);
               status_in = ST_OK;
               phase_in  = 1'b0;
               undo_in   = 1'b0;
               state_in  = (ldd_func_type'(req_func) == FN_UNUSED) ? S_DONE : S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (!st.scan_done) begin
               state_in = S_SCAN_CM;
            end else if (st.full) begin
               status_in = ST_FULL;
               state_in  = S_DONE;
            end else begin
               state_in = S_ALLOC_T;
            end
         end
         S_SCAN_CM: begin
            cmd.scan_cmp = 1'b1;
            state_in     = S_SCAN_RD;
         end
         S_ALLOC_T: begin
            cmd.alloc_t = 1'b1;
            state_in    = S_ALLOC_M;
         end
         S_ALLOC_M: begin
            cmd.alloc_m = 1'b1;
            sel_m_in    = (func_ff == FN_RELEASED);
            set_in      = (func_ff == FN_REQUEST);
            state_in    = S_EDGE_RD;
         end
         S_EDGE_RD: begin
            cmd.edge_rd = 1'b1;
            state_in    = S_EDGE_WR;
         end
         S_EDGE_WR: begin
            cmd.edge_wr   = 1'b1;
            cmd.dfs_clear = 1'b1;
            if (func_ff == FN_REQUEST && !undo_ff) begin
               state_in = S_ROOT;
            end else if (func_ff == FN_REQUEST) begin
               status_in = ST_DEADLOCK;
               state_in  = S_DONE;
            end else if (func_ff == FN_ACQUIRED && !phase_ff) begin
               phase_in = 1'b1;
               sel_m_in = 1'b1;
               set_in   = 1'b1;
               state_in = S_EDGE_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_ROOT: begin
            if (st.root_none) begin
               state_in = S_DONE;
            end else begin
               cmd.root = 1'b1;
               state_in = S_ROW;
            end
         end
         S_ROW: begin
            if (st.cycle) begin
               undo_in  = 1'b1;
               sel_m_in = 1'b0;
               set_in   = 1'b0;
               state_in = S_EDGE_RD;
            end else if (st.cand_any) begin
               cmd.push = 1'b1;
            end else begin
               cmd.pop  = 1'b1;
               state_in = st.sp_zero ? S_ROOT : S_POP;
            end
         end
         S_POP: begin
            cmd.pop_load = 1'b1;
            state_in     = S_ROW;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         func_ff      <= FN_UNUSED;
         status_ff    <= ST_OK;
         sel_m_ff     <= 1'b0;
         set_ff       <= 1'b0;
         phase_ff     <= 1'b0;
         undo_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         func_ff      <= func_in;
         status_ff    <= status_in;
         sel_m_ff     <= sel_m_in;
         set_ff       <= set_in;
         phase_ff     <= phase_in;
         undo_ff      <= undo_in;
      end
   end

`ifndef SYNTHESIS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE)) else $error("stray result");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !cmd.load) else $error("load while busy");
`endif

endmodule

[hw/rtl/ldd_dpath.sv]
// ----------------------------------------------------------------------------
// ldd_dpath
// Node table, adjacency store, search marks, walk stack and result register.
// ----------------------------------------------------------------------------
module ldd_dpath
   import ldd_pkg::*;
#(
   parameter int NODE_SLOTS = NODE_SLOTS_DEF,
   parameter int KEY_BITS   = KEY_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ldd_cmd_type               cmd,
   output ldd_stat_type              st,
   input  logic [ID_BITS-1:0]        req_thread_id,
   input  logic [ID_BITS-1:0]        req_mutex_id,
   output logic [1:0]                rsp_status,
   output logic [NODES_OUT_BITS-1:0] rsp_nodes_in_use
);

   localparam int IdxW = $clog2(NODE_SLOTS);
   localparam int CntW = $clog2(NODE_SLOTS + 1);
   localparam int KeyW = (KEY_BITS < ID_BITS) ? KEY_BITS : ID_BITS;

   logic [KeyW-1:0]       tkey_ff, mkey_ff;
   logic [CntW-1:0]       total_ff, scan_ff, sp_ff;
   logic                  t_found_ff, m_found_ff;
   logic [IdxW-1:0]       t_idx_ff, m_idx_ff, top_ff;
   logic [KeyW:0]         key_mem [NODE_SLOTS];
   logic [KeyW:0]         entry_ff;
   logic [NODE_SLOTS-1:0] edge_mem [NODE_SLOTS];
   logic [NODE_SLOTS-1:0] row_vld_ff;
   logic [NODE_SLOTS-1:0] row_q_ff;
   logic                  row_q_vld_ff;
   logic [NODE_SLOTS-1:0] seen_ff, path_ff;
   logic [IdxW-1:0]       stk_mem [NODE_SLOTS];
   logic [IdxW-1:0]       stk_q_ff;
   logic [1:0]            status_ff;
   logic [NODES_OUT_BITS-1:0] nodes_ff;

   logic [NODE_SLOTS-1:0] row, alloc_mask, unseen, cand;
   logic [IdxW-1:0]       root_idx, cand_idx, top_in, rd_addr, wr_addr, wr_bit;
   logic [CntW:0]         need, room;
   logic [NODE_SLOTS-1:0] wr_row;

   assign row = row_q_vld_ff ? row_q_ff : '0;

   // allocated nodes and lowest-index pickers
   always_comb begin
      root_idx = '0;
      cand_idx = '0;
      for (int i = 0; i < NODE_SLOTS; i++) begin
         alloc_mask[i] = CntW'(i) < total_ff;
      end
      unseen = alloc_mask & ~seen_ff;
      cand   = row & ~seen_ff;
      for (int i = NODE_SLOTS - 1; i >= 0; i--) begin
         if (unseen[i]) root_idx = IdxW'(i);
         if (cand[i])   cand_idx = IdxW'(i);
      end
   end

   // room check
   assign need = (CntW + 1)'(!t_found_ff) + (CntW + 1)'(!m_found_ff);
   assign room = (CntW + 1)'(NODE_SLOTS) - {1'b0, total_ff};

   assign st.scan_done = (scan_ff == total_ff);
   assign st.full      = need > room;
   assign st.root_none = (unseen == '0);
   assign st.cycle     = |(row & path_ff);
   assign st.cand_any  = |cand;
   assign st.sp_zero   = (sp_ff == '0);

   // next top of walk and row addresses
   always_comb begin
      if (cmd.root) top_in = root_idx;
      else if (cmd.push) top_in = cand_idx;
      else if (cmd.pop_load) top_in = stk_q_ff;
      else top_in = top_ff;
      wr_addr = cmd.row_sel_m ? m_idx_ff : t_idx_ff;
      wr_bit  = cmd.row_sel_m ? t_idx_ff : m_idx_ff;
      rd_addr = cmd.edge_rd ? wr_addr : top_in;
      wr_row  = row;
      wr_row[wr_bit] = cmd.wr_set;
   end

   // node table
   always_ff @(posedge clock) begin
      entry_ff <= key_mem[scan_ff[IdxW-1:0]];
      if (cmd.alloc_t && !t_found_ff) begin
         key_mem[total_ff[IdxW-1:0]] <= {1'b0, tkey_ff};
      end else if (cmd.alloc_m && !m_found_ff) begin
         key_mem[total_ff[IdxW-1:0]] <= {1'b1, mkey_ff};
      end
   end

   // lookup and allocation
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= '0;
         scan_ff    <= '0;
         t_found_ff <= 1'b0;
         m_found_ff <= 1'b0;
      end else if (cmd.load) begin
         scan_ff    <= '0;
         t_found_ff <= 1'b0;
         m_found_ff <= 1'b0;
      end else if (cmd.scan_cmp) begin
         scan_ff <= scan_ff + 1'b1;
         if (!entry_ff[KeyW] && entry_ff[KeyW-1:0] == tkey_ff) t_found_ff <= 1'b1;
         if (entry_ff[KeyW] && entry_ff[KeyW-1:0] == mkey_ff)  m_found_ff <= 1'b1;
      end else if ((cmd.alloc_t && !t_found_ff) || (cmd.alloc_m && !m_found_ff)) begin
         total_ff <= total_ff + 1'b1;
      end
   end

   // keys and node indexes
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tkey_ff <= req_thread_id[KeyW-1:0];
         mkey_ff <= req_mutex_id[KeyW-1:0];
      end
      if (cmd.scan_cmp) begin
         if (!entry_ff[KeyW] && entry_ff[KeyW-1:0] == tkey_ff) t_idx_ff <= scan_ff[IdxW-1:0];
         if (entry_ff[KeyW] && entry_ff[KeyW-1:0] == mkey_ff)  m_idx_ff <= scan_ff[IdxW-1:0];
      end
      if (cmd.alloc_t && !t_found_ff) t_idx_ff <= total_ff[IdxW-1:0];
      if (cmd.alloc_m && !m_found_ff) m_idx_ff <= total_ff[IdxW-1:0];
   end

   // adjacency store, rows never written read as zero
   always_ff @(posedge clock) begin
      row_q_ff <= edge_mem[rd_addr];
      if (cmd.edge_wr) edge_mem[wr_addr] <= wr_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff   <= '0;
         row_q_vld_ff <= 1'b0;
      end else begin
         row_q_vld_ff <= row_vld_ff[rd_addr];
         if (cmd.edge_wr) row_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // walk stack
   always_ff @(posedge clock) begin
      stk_q_ff <= stk_mem[IdxW'(sp_ff - 1'b1)];
      if (cmd.push) stk_mem[sp_ff[IdxW-1:0]] <= top_ff;
   end

   // search marks and walk depth
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         path_ff <= '0;
         sp_ff   <= '0;
         top_ff  <= '0;
      end else begin
         top_ff <= top_in;
         if (cmd.dfs_clear) begin
            seen_ff <= '0;
            path_ff <= '0;
            sp_ff   <= '0;
         end else if (cmd.root) begin
            seen_ff[root_idx] <= 1'b1;
            path_ff[root_idx] <= 1'b1;
         end else if (cmd.push) begin
            seen_ff[cand_idx] <= 1'b1;
            path_ff[cand_idx] <= 1'b1;
            sp_ff             <= sp_ff + 1'b1;
         end else if (cmd.pop) begin
            path_ff[top_ff] <= 1'b0;
            if (sp_ff != '0) sp_ff <= sp_ff - 1'b1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         status_ff <= cmd.rsp_status;
         nodes_ff  <= NODES_OUT_BITS'(total_ff);
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_nodes_in_use = nodes_ff;

`ifndef SYNTHESIS
   a_path_in_seen: assert property (@(posedge clock) disable iff (reset)
      (path_ff & ~seen_ff) == '0) else $error("path mark on unseen node");
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= CntW'(NODE_SLOTS)) else $error("walk stack overflow");
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CntW'(NODE_SLOTS)) else $error("node count overflow");
`endif

endmodule

[hw/rtl/lock_graph_deadlock_detector.sv]
// ----------------------------------------------------------------------------
// lock_graph_deadlock_detector
// Keeps a wait/hold graph of threads and locks and refuses deadlocking
// lock requests.
// ----------------------------------------------------------------------------
// Usage:
//  req_ch carries one event word (func, thread_id, mutex_id); rsp_ch returns
//  one result word (status, nodes_in_use) per event, in order.
//  Events are handled one at a time; req_ch.ready is high only when idle.
//  Each event first scans the node table, one entry per allocated node,
//  then allocates missing nodes and updates the edges.
//  A lock request also runs a depth-first search over the graph: each node
//  costs one row read on entry, and leaving it pops the walk stack; all
//  rows go through the single read port of the adjacency store.
//  The result sits in an output register: a stalled receiver does not stop
//  the next event from being accepted, but its result waits until the
//  register is free.
//  Reset (synchronous) empties the node table and marks all adjacency rows
//  as empty at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lock_graph_deadlock_detector
   import ldd_pkg::*;
#(
   parameter int NODE_SLOTS = NODE_SLOTS_DEF,
   parameter int KEY_BITS   = KEY_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   ldd_req_if.sink   req_ch,
   ldd_rsp_if.source rsp_ch
);

   ldd_cmd_type  cmd;
   ldd_stat_type st;

   // sequencer
   ldd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .st        (st),
      .cmd       (cmd)
   );

   // storage and search datapath
   ldd_dpath #(
      .NODE_SLOTS (NODE_SLOTS),
      .KEY_BITS   (KEY_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_thread_id    (req_ch.thread_id),
      .req_mutex_id     (req_ch.mutex_id),
      .rsp_status       (rsp_ch.status),
      .rsp_nodes_in_use (rsp_ch.nodes_in_use)
   );

endmodule
